// ----- src/sem_pkg.sv -----
// shared types, constants and register codes of the sobel edge magnitude stream
package sem_pkg;

   // default and largest sizes of the frame
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
   localparam logic [CSR_DATA_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
   localparam logic [CSR_DATA_W-1:0] RST_EDGE_THRESHOLD = 11'd0;

   // pixel word, red in the low byte and alpha in the high byte
   localparam int PIX_W = 32;

   // gradient, squared magnitude and root widths
   localparam int GRAD_W     = 11;
   localparam int ROOT_W     = 11;
   localparam int SQ_W       = 2 * ROOT_W - 1;
   localparam int ROOT_TOP   = 2 * (ROOT_W - 1);
   localparam int ROOT_STEPS = 4;

   localparam logic [7:0] CHAN_MAX = 8'd255;

   typedef struct packed {
      logic       is_flush;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       end_of_frame;
   } rsp_type;

endpackage

// ----- src/sem_line_buf.sv -----
// upper and middle line stores, one synchronous read port and one write port each
module sem_line_buf import sem_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] upper_q,
   output logic [PIX_W-1:0] middle_q,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] upper_wr,
   input  logic [PIX_W-1:0] middle_wr
);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_q  <= upper_mem[rd_addr];
         middle_q <= middle_mem[rd_addr];
      end
      if (wr_en) begin
         upper_mem[wr_addr]  <= upper_wr;
         middle_mem[wr_addr] <= middle_wr;
      end
   end

endmodule

// ----- src/sem_isqrt.sv -----
// iterative floor square root, four digit steps per cycle
module sem_isqrt import sem_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   operand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SQ_W:0]     rem_ff, rem_in;
   logic [SQ_W:0]     res_ff, res_in;
   logic [SQ_W:0]     bit_ff, bit_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0]   op_ff;

   always_comb begin
      logic [SQ_W:0] r, s, b;
      r = rem_ff;
      s = res_ff;
      b = bit_ff;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         if (b != '0) begin
            if (r >= s + b) begin
               r = r - (s + b);
               s = (s >> 1) + b;
            end else begin
               s = s >> 1;
            end
            b = b >> 2;
         end
      end
      run_in  = run_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      root_in = root_ff;
      if (start) begin
         run_in = 1'b1;
         rem_in = {1'b0, operand};
         res_in = '0;
         bit_in = (SQ_W+1)'(1) << ROOT_TOP;
      end else if (run_ff) begin
         rem_in = r;
         res_in = s;
         bit_in = b;
         if (b == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            root_in = s[ROOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      root_ff <= root_in;
      if (start) begin
         op_ff <= operand;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   // root is the floor of the square root of the operand
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ((2*ROOT_W)'(root_ff) * (2*ROOT_W)'(root_ff) <= (2*ROOT_W)'(op_ff)) &&
                  (((2*ROOT_W)'(root_ff) + (2*ROOT_W)'(1)) *
                   ((2*ROOT_W)'(root_ff) + (2*ROOT_W)'(1)) > (2*ROOT_W)'(op_ff)))
      else $error("square root result out of range");

   // a new operand never lands on a root in progress
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("square root restarted while busy");

endmodule

// ----- src/sobel_edge_magnitude_stream.sv -----
// top level: streaming 3x3 sobel edge magnitude on the red channel of an rgba raster
// latency: the result for a pixel leaves one line plus one pixel of beats later; after
//   S_READ a border result goes to S_FIN, an interior one via S_GRAD, S_SQR, S_LOAD, S_ROOT
// sequencing: a new beat is taken only in S_IDLE; S_ROOT waits for the 11-step root and
//   S_FIN for the output; beats without result end after S_READ, ignored flushes in S_IDLE
// reset: synchronous, clears the state machine, counters, window and output valid; the
//   line stores come up undefined and their contents reach a result only where they were written in the frame
module sobel_edge_magnitude_stream import sem_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // counter and size widths
   localparam int CA  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int IRW = $clog2(MAX_HEIGHT + 2);
   localparam int ORW = $clog2(MAX_HEIGHT);
   localparam int WCW = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int HCW = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;

   // item sequencer
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_GRAD = 3'd2;
   localparam logic [2:0] S_SQR  = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;
   localparam logic [2:0] S_ROOT = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   function automatic logic signed [GRAD_W-1:0] px_ext(input logic [7:0] p);
      return signed'({{(GRAD_W-8){1'b0}}, p});
   endfunction

   // configuration registers
   logic [CSR_DATA_W-1:0] image_width_ff, image_height_ff, edge_threshold_ff;

   // control state
   logic [2:0]     state_ff, state_in;
   logic [CA-1:0]  input_column_ff, input_column_in;
   logic [IRW-1:0] input_row_ff, input_row_in;
   logic [CA-1:0]  output_column_ff, output_column_in;
   logic [ORW-1:0] output_row_ff, output_row_in;
   logic           rsp_valid_ff;

   // per-beat flags held while the beat is worked on
   logic             emit_ff, interior_ff, eof_ff;
   logic [CA-1:0]    col_ff;
   logic [PIX_W-1:0] pixel_ff;

   // window, delayed centre pixel and datapath registers
   logic [7:0]               win_ff [3][3];
   logic [PIX_W-1:0]         delayed_ff;
   logic [PIX_W-1:0]         out_pix_ff;
   logic signed [GRAD_W-1:0] grad_h_ff, grad_v_ff;
   logic [SQ_W-1:0]          hsq_ff, vsq_ff;
   rsp_type                  rsp_ff, rsp_in;

   // combinational
   logic [WCW-1:0]             wreg;
   logic [HCW-1:0]             hreg;
   logic [WW-1:0]              w, col_p1, oc_p1;
   logic [HW-1:0]              h;
   logic [IRW-1:0]             h_ir, orow_p1;
   logic                       drain, emit, interior, eof, col_last, oc_last, or_last;
   logic                       ignore, item_go, rsp_load;
   logic [PIX_W-1:0]           upper_q, middle_q;
   logic signed [GRAD_W-1:0]   grad_h, grad_v;
   logic signed [2*GRAD_W-1:0] hprod, vprod;
   logic                       root_start, root_done;
   logic [ROOT_W-1:0]          root;
   logic [ROOT_W-1:0]          mag;
   logic [7:0]                 edge_val;

   // sizes clamped to 1..max
   always_comb begin
      wreg = WCW'(image_width_ff);
      hreg = HCW'(image_height_ff);
      if (wreg == '0) begin
         w = WW'(1);
      end else if (wreg > WCW'(MAX_WIDTH)) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(wreg);
      end
      if (hreg == '0) begin
         h = HW'(1);
      end else if (hreg > HCW'(MAX_HEIGHT)) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(hreg);
      end
   end

   // position decode for the beat on offer
   assign h_ir     = IRW'(h);
   assign col_p1   = WW'(input_column_ff) + WW'(1);
   assign oc_p1    = WW'(output_column_ff) + WW'(1);
   assign orow_p1  = IRW'(output_row_ff) + IRW'(1);
   assign col_last = col_p1 >= w;
   assign oc_last  = oc_p1 >= w;
   assign or_last  = orow_p1 >= h_ir;
   assign drain    = input_row_ff >= h_ir;
   assign emit     = (input_row_ff >= IRW'(2)) ||
                     ((input_row_ff == IRW'(1)) && (input_column_ff != '0));
   assign interior = (output_column_ff != '0) && !oc_last &&
                     (output_row_ff != '0) && !or_last;
   assign eof      = or_last && oc_last;

   // a flush while pixels are still due is dropped without effect
   assign ignore    = !drain && req_data.is_flush;
   assign req_ready = (state_ff == S_IDLE);
   assign item_go   = req_valid && req_ready && !ignore;
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // counters move at acceptance; nothing else is accepted until the beat is done
   always_comb begin
      input_column_in  = input_column_ff;
      input_row_in     = input_row_ff;
      output_column_in = output_column_ff;
      output_row_in    = output_row_ff;
      if (item_go) begin
         if (emit && eof) begin
            input_column_in  = '0;
            input_row_in     = '0;
            output_column_in = '0;
            output_row_in    = '0;
         end else begin
            if (emit) begin
               if (oc_last) begin
                  output_column_in = '0;
                  output_row_in    = ORW'(orow_p1);
               end else begin
                  output_column_in = CA'(oc_p1);
               end
            end
            if (col_last) begin
               input_column_in = '0;
               if (input_row_ff <= h_ir) begin
                  input_row_in = input_row_ff + IRW'(1);
               end
            end else begin
               input_column_in = CA'(col_p1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_go) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!emit_ff) begin
               state_in = S_IDLE;
            end else if (interior_ff) begin
               state_in = S_GRAD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_GRAD: state_in = S_SQR;
         S_SQR:  state_in = S_LOAD;
         S_LOAD: state_in = S_ROOT;
         S_ROOT: begin
            if (root_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // line stores: read at acceptance, written back in the following cycle
   sem_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (CA)
   ) u_line_buf (
      .clock     (clock),
      .rd_en     (item_go),
      .rd_addr   (input_column_ff),
      .upper_q   (upper_q),
      .middle_q  (middle_q),
      .wr_en     (state_ff == S_READ),
      .wr_addr   (col_ff),
      .upper_wr  (middle_q),
      .middle_wr (pixel_ff)
   );

   // sobel kernels on the red window
   assign grad_h = px_ext(win_ff[0][0]) - px_ext(win_ff[0][2])
                 + (px_ext(win_ff[1][0]) <<< 1) - (px_ext(win_ff[1][2]) <<< 1)
                 + px_ext(win_ff[2][0]) - px_ext(win_ff[2][2]);
   assign grad_v = px_ext(win_ff[2][0]) + (px_ext(win_ff[2][1]) <<< 1) + px_ext(win_ff[2][2])
                 - px_ext(win_ff[0][0]) - (px_ext(win_ff[0][1]) <<< 1) - px_ext(win_ff[0][2]);

   assign hprod = grad_h_ff * grad_h_ff;
   assign vprod = grad_v_ff * grad_v_ff;

   assign root_start = (state_ff == S_LOAD);

   sem_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (hsq_ff + vsq_ff),
      .done    (root_done),
      .root    (root)
   );

   // threshold, clamp and result beat
   assign mag      = (CSR_DATA_W'(root) <= edge_threshold_ff) ? '0 : root;
   assign edge_val = (mag > ROOT_W'(CHAN_MAX)) ? CHAN_MAX : mag[7:0];

   always_comb begin
      rsp_in.alpha_out    = out_pix_ff[31:24];
      rsp_in.end_of_frame = eof_ff;
      if (interior_ff) begin
         rsp_in.red_out   = edge_val;
         rsp_in.green_out = edge_val;
         rsp_in.blue_out  = edge_val;
      end else begin
         rsp_in.red_out   = out_pix_ff[7:0];
         rsp_in.green_out = out_pix_ff[15:8];
         rsp_in.blue_out  = out_pix_ff[23:16];
      end
   end

   // configuration writes, always taken; indexes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RST_IMAGE_WIDTH;
         image_height_ff   <= RST_IMAGE_HEIGHT;
         edge_threshold_ff <= RST_EDGE_THRESHOLD;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data;
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data;
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         input_column_ff  <= '0;
         input_row_ff     <= '0;
         output_column_ff <= '0;
         output_row_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         delayed_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff         <= state_in;
         input_column_ff  <= input_column_in;
         input_row_ff     <= input_row_in;
         output_column_ff <= output_column_in;
         output_row_ff    <= output_row_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // window shifts and the centre pixel moves on once the stores are read
         if (state_ff == S_READ) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= upper_q[7:0];
            win_ff[1][2] <= middle_q[7:0];
            win_ff[2][2] <= pixel_ff[7:0];
            delayed_ff   <= middle_q;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (item_go) begin
         emit_ff     <= emit;
         interior_ff <= interior;
         eof_ff      <= eof;
         col_ff      <= input_column_ff;
         // drain beats push an empty pixel through the stores
         pixel_ff    <= drain ? '0 : {req_data.alpha_in, req_data.blue_in,
                                      req_data.green_in, req_data.red_in};
      end
      if (state_ff == S_READ) begin
         out_pix_ff <= delayed_ff;
      end
      if (state_ff == S_GRAD) begin
         grad_h_ff <= grad_h;
         grad_v_ff <= grad_v;
      end
      if (state_ff == S_SQR) begin
         hsq_ff <= hprod[SQ_W-1:0];
         vsq_ff <= vprod[SQ_W-1:0];
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted pixel or drain beat always goes to the store read
   a_go_reads: assert property (@(posedge clock) disable iff (reset)
      item_go |=> (state_ff == S_READ))
      else $error("accepted beat did not start a store read");

   // the frame end beat finds every position counter back at zero
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.end_of_frame) |->
         (input_column_ff == '0) && (input_row_ff == '0) &&
         (output_column_ff == '0) && (output_row_ff == '0))
      else $error("frame end without counter clear");

   // the root only finishes while the sequencer waits for it
   a_root_wait: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_ROOT))
      else $error("square root finished outside its wait state");

endmodule
